>>> hw/rtl/mi3_pkg.sv
// Shared widths, types and cofactor index table for the 3x3 matrix inverse core.
package mi3_pkg;

    // Element width and fixed-point layout (Q4.12 at 16 bits).
    localparam int ELEM_BITS = 16;
    localparam int FRAC_BITS = ELEM_BITS - 4;
    localparam int N_ELEM    = 9;
    localparam int OUT_W     = 32;

    // Exact widths of the intermediate values.
    localparam int PROD_W = 2 * ELEM_BITS;
    localparam int COF_W  = PROD_W + 1;
    localparam int TERM_W = ELEM_BITS + COF_W;
    localparam int DET_W  = TERM_W + 2;

    // Divider layout: numerator is |cofactor| << SHIFT, QB quotient bits are resolved.
    localparam int SHIFT = FRAC_BITS + 16;
    localparam int NUM_W = COF_W + SHIFT;
    localparam int QB    = OUT_W + 1;
    localparam int RI_W  = NUM_W - QB;

    // Pipeline depth.
    localparam int FRONT_LAT = 4;
    localparam int LANE_LAT  = QB + 2;
    localparam int LAT       = FRONT_LAT + LANE_LAT;

    // Saturation limits on the rounded magnitude.
    localparam logic [QB:0] LIM_POS = (QB + 1)'((64'd1 << (OUT_W - 1)) - 64'd1);
    localparam logic [QB:0] LIM_NEG = (QB + 1)'(64'd1 << (OUT_W - 1));

    typedef logic signed [ELEM_BITS-1:0] elem_t;
    typedef logic signed [COF_W-1:0]     cof_t;
    typedef logic [DET_W-1:0]            dmag_t;

    // Cofactor k is a[i0]*a[i1] - a[i2]*a[i3], elements indexed 3*row+col.
    localparam int COF_IDX [N_ELEM][4] = '{
        '{4, 8, 5, 7}, '{7, 2, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 3, 1}
    };

    // One stage of the restoring divider.
    typedef struct packed {
        dmag_t             r;
        logic [QB-1:0]     nb;
        logic [QB-1:0]     q;
        dmag_t             d;
        logic              neg;
        logic              ovf;
        logic              zero;
    } div_stage_t;

endpackage

>>> hw/rtl/mi3_front.sv
// Front end: 2x2 cofactor products, adjugate entries and the determinant.
module mi3_front
    import mi3_pkg::*;
(
    input  logic  aclk,
    input  logic  en,
    input  elem_t a   [N_ELEM],
    output cof_t  cof [N_ELEM],
    output dmag_t dmag,
    output logic  dneg,
    output logic  dzero
);

    logic signed [PROD_W-1:0] pa_reg [N_ELEM];
    logic signed [PROD_W-1:0] pb_reg [N_ELEM];
    elem_t                    r0_reg [2][3];
    cof_t                     cof_reg [3][N_ELEM];
    logic signed [TERM_W-1:0] term_reg [3];
    logic signed [DET_W-1:0]  det_next;
    dmag_t                    dmag_reg;
    logic                     dneg_reg;
    logic                     dzero_reg;

    // Stage one: the eighteen element products; first row held for the expansion.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < N_ELEM; k++) begin
                pa_reg[k] <= a[COF_IDX[k][0]] * a[COF_IDX[k][1]];
                pb_reg[k] <= a[COF_IDX[k][2]] * a[COF_IDX[k][3]];
            end
            for (int j = 0; j < 3; j++) begin
                r0_reg[0][j] <= a[j];
            end
        end
    end

    // Stage two: cofactor differences.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < N_ELEM; k++) begin
                cof_reg[0][k] <= COF_W'(pa_reg[k]) - COF_W'(pb_reg[k]);
            end
            for (int j = 0; j < 3; j++) begin
                r0_reg[1][j] <= r0_reg[0][j];
            end
        end
    end

    // Stage three: Laplace terms along the first row.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                term_reg[j] <= r0_reg[1][j] * cof_reg[0][3*j];
            end
            cof_reg[1] <= cof_reg[0];
        end
    end

    // Stage four: determinant sum, sign and magnitude.
    always_comb begin
        det_next = DET_W'(term_reg[0]) + DET_W'(term_reg[1]) + DET_W'(term_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dneg_reg  <= det_next[DET_W-1];
            dmag_reg  <= det_next[DET_W-1] ? dmag_t'(-det_next) : dmag_t'(det_next);
            dzero_reg <= (det_next == '0);
            cof_reg[2] <= cof_reg[1];
        end
    end

    assign cof   = cof_reg[2];
    assign dmag  = dmag_reg;
    assign dneg  = dneg_reg;
    assign dzero = dzero_reg;

endmodule

>>> hw/rtl/mi3_div_lane.sv
// One lane: pipelined restoring division of a cofactor by the determinant, Q16.16 out.
module mi3_div_lane
    import mi3_pkg::*;
(
    input  logic             aclk,
    input  logic             en,
    input  cof_t             cof,
    input  dmag_t            dmag,
    input  logic             dneg,
    input  logic             dzero,
    output logic [OUT_W-1:0] res,
    output logic             sing
);

    div_stage_t         stg_reg [QB+1];
    logic [COF_W-1:0]   cmag;
    logic [NUM_W-1:0]   num;
    logic [RI_W-1:0]    rinit;
    logic               rnd;
    logic [QB:0]        qr;
    logic [QB:0]        lim;
    logic               sat;
    logic [OUT_W-1:0]   mag;
    logic [OUT_W-1:0]   res_reg;
    logic               sing_reg;

    // Set-up: numerator, top remainder and the overflow test.
    always_comb begin
        cmag  = cof[COF_W-1] ? COF_W'(-cof) : COF_W'(cof);
        num   = {cmag, {SHIFT{1'b0}}};
        rinit = num[NUM_W-1 -: RI_W];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stg_reg[0].r    <= DET_W'(rinit);
            stg_reg[0].nb   <= num[QB-1:0];
            stg_reg[0].q    <= '0;
            stg_reg[0].d    <= dmag;
            stg_reg[0].neg  <= cof[COF_W-1] ^ dneg;
            stg_reg[0].ovf  <= (DET_W'(rinit) >= dmag);
            stg_reg[0].zero <= dzero;
        end
    end

    // One quotient bit per stage.
    for (genvar k = 0; k < QB; k++) begin : g_step
        logic [DET_W:0] trial;
        logic           ge;

        always_comb begin
            trial = {stg_reg[k].r, stg_reg[k].nb[QB-1]};
            ge    = (trial >= {1'b0, stg_reg[k].d});
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                stg_reg[k+1].r    <= ge ? DET_W'(trial - {1'b0, stg_reg[k].d})
                                        : trial[DET_W-1:0];
                stg_reg[k+1].nb   <= {stg_reg[k].nb[QB-2:0], 1'b0};
                stg_reg[k+1].q    <= {stg_reg[k].q[QB-2:0], ge};
                stg_reg[k+1].d    <= stg_reg[k].d;
                stg_reg[k+1].neg  <= stg_reg[k].neg;
                stg_reg[k+1].ovf  <= stg_reg[k].ovf;
                stg_reg[k+1].zero <= stg_reg[k].zero;
            end
        end
    end

    // Round half away from zero, saturate, apply the sign.
    always_comb begin
        rnd = ({stg_reg[QB].r, 1'b0} >= {1'b0, stg_reg[QB].d});
        qr  = {1'b0, stg_reg[QB].q} + (QB + 1)'(rnd);
        lim = stg_reg[QB].neg ? LIM_NEG : LIM_POS;
        sat = stg_reg[QB].ovf || (qr > lim);
        mag = sat ? lim[OUT_W-1:0] : qr[OUT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg  <= stg_reg[QB].zero ? '0 : (stg_reg[QB].neg ? -mag : mag);
            sing_reg <= stg_reg[QB].zero;
        end
    end

    assign res  = res_reg;
    assign sing = sing_reg;

endmodule

>>> hw/rtl/matrix_inverse_3x3_core.sv
// Top level of the 3x3 matrix inverse core: front end, nine division lanes, output merge.
// The core inverts one 3x3 matrix of signed Q4.12 elements per beat by the adjugate
// method and returns the nine entries as signed Q16.16, rounded to nearest with ties
// away from zero and saturated; a zero determinant sets m_tuser and returns zeros.
// It accepts a matrix every cycle while the output is not stalled; each result passes
// through four front-end stages (products, cofactors, expansion terms, determinant),
// then one set-up stage, 33 one-bit restoring divider stages and a rounding stage in
// each of nine parallel lanes. A stalled result holds the whole pipeline.
module matrix_inverse_3x3_core
    import mi3_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    // tdata: a00, a01, a02, a10, a11, a12, a20, a21, a22 (16 bits each, lowest first)
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [143:0]   s_tdata,
    // tdata: b00, b01, b02, b10, b11, b12, b20, b21, b22 (32 bits each, lowest first)
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [287:0]   m_tdata,
    // tuser: singular
    output logic           m_tuser
);

    logic             en;
    logic [LAT-1:0]   vld_reg;
    logic [LAT-1:0]   vld_next;
    elem_t            a     [N_ELEM];
    cof_t             cof   [N_ELEM];
    dmag_t            dmag;
    logic             dneg;
    logic             dzero;
    logic [OUT_W-1:0] res   [N_ELEM];
    logic [N_ELEM-1:0] sing;

    // The pipeline advances unless a finished beat is held at the output.
    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;

    // Unpack the input beat.
    always_comb begin
        for (int k = 0; k < N_ELEM; k++) begin
            a[k] = s_tdata[k*ELEM_BITS +: ELEM_BITS];
        end
    end

    // Valid bits follow the data through every stage.
    always_comb begin
        vld_next = {vld_reg[LAT-2:0], s_tvalid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    mi3_front u_front (
        .aclk  (aclk),
        .en    (en),
        .a     (a),
        .cof   (cof),
        .dmag  (dmag),
        .dneg  (dneg),
        .dzero (dzero)
    );

    for (genvar k = 0; k < N_ELEM; k++) begin : g_lane
        mi3_div_lane u_lane (
            .aclk  (aclk),
            .en    (en),
            .cof   (cof[k]),
            .dmag  (dmag),
            .dneg  (dneg),
            .dzero (dzero),
            .res   (res[k]),
            .sing  (sing[k])
        );
    end

    // Merge the lane results into the output beat.
    always_comb begin
        for (int k = 0; k < N_ELEM; k++) begin
            m_tdata[k*OUT_W +: OUT_W] = res[k];
        end
    end

    assign m_tuser  = &sing;
    assign m_tvalid = vld_reg[LAT-1];

    // A singular result carries all-zero entries.
    a_sing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("singular result with non-zero entries");

    // The lanes agree on the singular flag.
    a_sing_agree: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (sing == '0 || sing == '1))
        else $error("lanes disagree on singular flag");

    // An accepted beat enters the first pipeline stage.
    a_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted beat lost at pipeline entry");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

>>> bench/tb.sv
// Self-checking testbench for the 3x3 matrix inverse core.
`timescale 1ns / 1ps

module tb;
    import mi3_pkg::*;

    logic           aclk;
    logic           aresetn;
    logic           s_tvalid;
    logic           s_tready;
    logic [143:0]   s_tdata;   // a00, a01, a02, a10, a11, a12, a20, a21, a22 (16 bits each)
    logic           m_tvalid;
    logic           m_tready;
    logic [287:0]   m_tdata;   // b00, b01, b02, b10, b11, b12, b20, b21, b22 (32 bits each)
    logic           m_tuser;   // singular

    typedef struct packed {
        logic [287:0] inv;
        logic         sing;
    } inverse_t;

    inverse_t    pending_inverses[$];
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_recv;
    int          fail_count;
    int          beats_in;
    int          beats_out;
    int          singular_seen;
    int          quiet_cycles;

    localparam int QUIET_LIMIT = 20000;

    matrix_inverse_3x3_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Rounded, saturated quotient of cofactor times 2^28 over the determinant.
    function automatic logic [31:0] div_entry(logic signed [63:0] cof,
                                              logic signed [127:0] det);
        logic [127:0] num;
        logic [127:0] dmag;
        logic [127:0] quo;
        logic [127:0] rem;
        logic         neg;
        logic [127:0] lim;
        if (cof == 0) begin
            return 32'd0;
        end
        num  = (cof < 0) ? 128'(-cof) : 128'(cof);
        num  = num << (FRAC_BITS + 16);
        dmag = (det < 0) ? 128'(-det) : 128'(det);
        quo  = num / dmag;
        rem  = num % dmag;
        if ((rem << 1) >= dmag) begin
            quo = quo + 1;
        end
        neg = (cof < 0) != (det < 0);
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (quo > lim) begin
            quo = lim;
        end
        return neg ? 32'(-quo) : quo[31:0];
    endfunction

    // Adjugate over determinant for one packed matrix.
    function automatic inverse_t invert_matrix(logic [143:0] mat);
        logic signed [63:0]  e[9];
        logic signed [63:0]  adj[9];
        logic signed [127:0] det;
        inverse_t            res;
        for (int i = 0; i < 9; i++) begin
            e[i] = 64'(signed'(mat[16*i +: 16]));
        end
        adj[0] = e[4] * e[8] - e[5] * e[7];
        adj[1] = e[7] * e[2] - e[1] * e[8];
        adj[2] = e[1] * e[5] - e[2] * e[4];
        adj[3] = e[5] * e[6] - e[3] * e[8];
        adj[4] = e[0] * e[8] - e[2] * e[6];
        adj[5] = e[2] * e[3] - e[0] * e[5];
        adj[6] = e[3] * e[7] - e[4] * e[6];
        adj[7] = e[1] * e[6] - e[0] * e[7];
        adj[8] = e[0] * e[4] - e[3] * e[1];
        det = 128'(e[0]) * 128'(adj[0]) + 128'(e[1]) * 128'(adj[3])
            + 128'(e[2]) * 128'(adj[6]);
        res = '0;
        if (det == 0) begin
            res.sing = 1'b1;
        end else begin
            for (int i = 0; i < 9; i++) begin
                res.inv[32*i +: 32] = div_entry(adj[i], det);
            end
        end
        return res;
    endfunction

    // Offer one matrix, with random idle cycles first, and wait for its beat.
    // Valid stays high after the beat so that the next send can follow directly.
    task automatic send_matrix(logic [143:0] mat);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= mat;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        pending_inverses.push_back(invert_matrix(mat));
        beats_in++;
    endtask

    function automatic logic [143:0] pack9(logic [15:0] v[9]);
        logic [143:0] m;
        for (int i = 0; i < 9; i++) begin
            m[16*i +: 16] = v[i];
        end
        return m;
    endfunction

    function automatic logic [15:0] rand_elem();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 64)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    // Matrix with structure: random, singular by repeated row or zero column, or near-diagonal.
    function automatic logic [143:0] rand_matrix();
        logic [15:0] v[9];
        for (int i = 0; i < 9; i++) begin
            v[i] = rand_elem();
        end
        case ($urandom_range(9))
            0: begin
                for (int c = 0; c < 3; c++) v[6 + c] = v[c];
            end
            1: begin
                for (int r = 0; r < 3; r++) v[3*r + 2] = 16'd0;
            end
            2: begin
                for (int i = 0; i < 9; i++) begin
                    if (i % 4 != 0) v[i] = 16'($urandom_range(0, 16)) - 16'd8;
                end
            end
            default: ;
        endcase
        return pack9(v);
    endfunction

    // Receiver: random back-pressure, or held off entirely when requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each result beat with the oldest expected inverse.
    always @(posedge aclk) begin
        inverse_t want;
        if (aresetn && m_tvalid && m_tready) begin
            beats_out++;
            if (pending_inverses.size() == 0) begin
                $error("result beat with no matrix outstanding");
                fail_count++;
            end else begin
                want = pending_inverses.pop_front();
                if (m_tuser) singular_seen++;
                for (int i = 0; i < 9; i++) begin
                    if (m_tdata[32*i +: 32] !== want.inv[32*i +: 32]) begin
                        $error("b%0d%0d expected %h got %h", i / 3, i % 3,
                               want.inv[32*i +: 32], m_tdata[32*i +: 32]);
                        fail_count++;
                    end
                end
                if (m_tuser !== want.sing) begin
                    $error("singular expected %b got %b", want.sing, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[matrix_inverse_3x3_core] ERROR");
            $finish;
        end
    end

    task automatic test_corner_matrices();
        logic [15:0] v[9];
        logic [15:0] vals[4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
        // Identity, negated identity and zero matrix.
        v = '{16'h1000, 0, 0, 0, 16'h1000, 0, 0, 0, 16'h1000};
        send_matrix(pack9(v));
        v = '{16'hF000, 0, 0, 0, 16'hF000, 0, 0, 0, 16'hF000};
        send_matrix(pack9(v));
        send_matrix('0);
        // Tiny determinant gives large entries; huge diagonal gives small entries.
        v = '{16'h0001, 0, 0, 0, 16'h0001, 0, 0, 0, 16'h0001};
        send_matrix(pack9(v));
        v = '{16'h8000, 0, 0, 0, 16'h8000, 0, 0, 0, 16'h8000};
        send_matrix(pack9(v));
        v = '{16'h7FFF, 0, 0, 0, 16'h8000, 0, 0, 0, 16'h7FFF};
        send_matrix(pack9(v));
        v = '{16'hFFFF, 0, 0, 0, 16'h0001, 0, 0, 0, 16'h0001};
        send_matrix(pack9(v));
        // A small diagonal entry gives an inexact quotient to round; all-equal rows are singular.
        v = '{16'h0003, 0, 0, 0, 16'h1000, 0, 0, 0, 16'h1000};
        send_matrix(pack9(v));
        send_matrix({9{16'h7FFF}});
        send_matrix({9{16'h8000}});
        send_matrix({9{16'hAAAA}});
        send_matrix({9{16'h5555}});
        for (int k = 0; k < 12; k++) begin
            for (int i = 0; i < 9; i++) v[i] = vals[$urandom_range(3)];
            send_matrix(pack9(v));
        end
    endtask

    task automatic test_random_matrices(int count, int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int k = 0; k < count; k++) begin
            send_matrix(rand_matrix());
        end
    endtask

    // Hold the receiver off long enough that the pipeline fills and stalls input.
    task automatic test_full_pipeline();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            begin
                hold_recv = 1'b1;
                repeat (200) @(posedge aclk);
                hold_recv = 1'b0;
            end
            for (int k = 0; k < 100; k++) send_matrix(rand_matrix());
        join
    endtask

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        hold_recv     = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fail_count    = 0;
        beats_in      = 0;
        beats_out     = 0;
        singular_seen = 0;
        quiet_cycles  = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_corner_matrices();
        test_random_matrices(480, 27, 52);
        test_random_matrices(480, 52, 27);
        test_full_pipeline();
        test_random_matrices(460, 0, 0);
        s_tvalid <= 1'b0;

        while (pending_inverses.size() != 0) @(posedge aclk);
        repeat (2 * LAT) @(posedge aclk);

        $display("Inverted %0d matrices (%0d singular) under random and full back-pressure,",
                 beats_out, singular_seen);
        $display("%0d sent; %0d mismatches.", beats_in, fail_count);
        if (fail_count == 0) begin
            $display("[matrix_inverse_3x3_core] OK");
        end else begin
            $display("[matrix_inverse_3x3_core] ERROR");
        end
        $finish;
    end

endmodule
